[sv/text_console_cursor_scroll_top_defines.svh]
// Assertion helpers for the block that checks its own logic.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define TCCS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("text console check failed");

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define TCCS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("text console check failed");

`endif

[sv/tccs_pkg.sv]
package tccs_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CELL_W = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'h0a;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0f;

  // Register word index on the configuration port.
  localparam logic REG_TEXT_ATTR = 1'b0;

  // Request kinds.
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

endpackage

[sv/tccs_screen_ram.sv]
module tccs_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tccs_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tccs_pkg::CELL_W-1:0] rdata_o
);
  import tccs_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tccs_addr_unit.sv]
// Shared modular adder: sum_o = (a_i + b_i) mod CELLS, registered.
// Both operands are expected below CELLS.
module tccs_addr_unit #(
  parameter int CELLS = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic [AW-1:0] a_i,
  input  logic [AW-1:0] b_i,
  output logic [AW-1:0] sum_o
);

  logic [AW:0]   raw_w;
  logic [AW:0]   fold_w;
  logic [AW-1:0] sum_q;

  always_comb begin
    raw_w = {1'b0, a_i} + {1'b0, b_i};
    if (raw_w >= (AW + 1)'(CELLS)) begin
      fold_w = raw_w - (AW + 1)'(CELLS);
    end else begin
      fold_w = raw_w;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= fold_w[AW-1:0];
  end

  assign sum_o = sum_q;

endmodule

[sv/text_console_cursor_scroll_top.sv]
// Text console engine over a COLUMNS x ROWS screen of 16-bit cells (attribute
// in the high byte, character in the low byte). After reset the block sweeps
// the screen memory to zero, one cell per cycle; in_ready_o stays low
// meanwhile while configuration writes are taken as usual. Requests are then
// handled one at a time by a small sequencer around a single shared modular
// adder that forms every request and blanking address. A newline passes
// through CALC and DONE, a character put through CALC, WR and DONE, and a
// cell read through CALC, RD and DONE (CALC and DONE when the index lies past
// the screen). A request that scrolls also passes through SCRL, BLANK and
// BLANK_END: the screen is kept as a ring of rows, so a scroll only moves the
// top-row base by one row and fills the freed row with spaces, one cell per
// cycle through the shared adder. A finished result sits in an output
// register, so a new request is accepted while the previous result still
// waits.
module text_console_cursor_scroll_top #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_position_o,
  output logic [15:0] cell_data_o,
  output logic        scrolled_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tccs_pkg::*;
  `include "text_console_cursor_scroll_top_defines.svh"

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_ROW_START = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE     = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL      = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COL       = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW       = RW'(ROWS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WR,
    ST_RD,
    ST_SCRL,
    ST_BLANK,
    ST_BLANK_END,
    ST_DONE
  } state_e;

  // Configuration register. Writes complete in the access phase; pready is
  // tied high so every access finishes without wait states.
  logic [7:0] attr_q;
  logic       cfg_wr_w;

  assign pready   = 1'b1;
  assign cfg_wr_w = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR);
  assign prdata   = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, attr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_wr_w) begin
      attr_q <= pwdata[7:0];
    end
  end

  // Sequencer state, cursor and ring bookkeeping.
  state_e        state_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [AW-1:0] lin_q;       // row_q * COLUMNS + col_q, kept incrementally
  logic [AW-1:0] base_q;      // memory address of the top screen row
  logic [AW-1:0] blk_base_q;  // memory address of the row being blanked
  logic [AW-1:0] clr_cnt_q;
  logic [CW-1:0] blk_cnt_q;

  // Latched request.
  logic          act_q;
  logic [7:0]    code_q;
  logic [10:0]   idx_q;
  logic          scr_q;
  logic          rd_ok_q;

  // Result register.
  logic          out_valid_q;
  logic [10:0]   cur_out_q;
  logic [15:0]   data_out_q;
  logic          scr_out_q;

  // Shared adder and memory hookup.
  logic [AW-1:0]     op_a_w;
  logic [AW-1:0]     op_b_w;
  logic [AW-1:0]     sum_w;
  logic              ram_we_w;
  logic [AW-1:0]     ram_waddr_w;
  logic [CELL_W-1:0] ram_wdata_w;
  logic              ram_re_w;
  logic [CELL_W-1:0] ram_rdata_w;

  logic          in_range_w;
  logic          load_out_w;
  logic [AW-1:0] lin_nl_w;
  logic [31:0]   lin_ext_w;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_range_w  = 32'(idx_q) < 32'(CELLS);
  assign load_out_w  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  // A newline that stays on screen lands at the start of the next row.
  assign lin_nl_w    = lin_q + ROW_STRIDE - AW'(col_q);
  assign lin_ext_w   = 32'(lin_q);

  // Operand selection for the shared adder. Its result is registered and seen in the next cycle.
  always_comb begin
    op_a_w = base_q;
    op_b_w = ROW_STRIDE;
    case (state_q)
      ST_CALC: begin
        if (act_q == ACT_READ) begin
          op_a_w = AW'(idx_q);
          op_b_w = base_q;
        end else if (code_q != NEWLINE_CODE) begin
          op_a_w = lin_q;
          op_b_w = base_q;
        end
      end
      ST_BLANK: begin
        op_a_w = blk_base_q;
        op_b_w = AW'(blk_cnt_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we_w    = 1'b0;
    ram_waddr_w = sum_w;
    ram_wdata_w = {attr_q, SPACE_CODE};
    ram_re_w    = (state_q == ST_RD);
    case (state_q)
      ST_CLEAR: begin
        ram_we_w    = 1'b1;
        ram_waddr_w = clr_cnt_q;
        ram_wdata_w = '0;
      end
      ST_WR: begin
        ram_we_w    = 1'b1;
        ram_wdata_w = {attr_q, code_q};
      end
      ST_BLANK: begin
        // The first blank address is still being formed in the adder.
        ram_we_w = (blk_cnt_q != '0);
      end
      ST_BLANK_END: begin
        ram_we_w = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tccs_addr_unit #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_addr (
    .clk_i (clk_i),
    .a_i   (op_a_w),
    .b_i   (op_b_w),
    .sum_o (sum_w)
  );

  tccs_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we_w),
    .waddr_i (ram_waddr_w),
    .wdata_i (ram_wdata_w),
    .re_i    (ram_re_w),
    .raddr_i (sum_w),
    .rdata_o (ram_rdata_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      lin_q       <= '0;
      base_q      <= '0;
      blk_base_q  <= '0;
      clr_cnt_q   <= '0;
      blk_cnt_q   <= '0;
      act_q       <= ACT_PUT;
      code_q      <= '0;
      idx_q       <= '0;
      scr_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cur_out_q   <= '0;
      data_out_q  <= '0;
      scr_out_q   <= 1'b0;
    end else begin
      // A result taken in the cycle that a new one is posted is replaced below.
      if (out_valid_q && out_ready_i && !load_out_w) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == LAST_CELL) begin
            state_q <= ST_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end

        ST_IDLE: begin
          if (in_valid_i) begin
            act_q   <= action_i;
            code_q  <= char_code_i;
            idx_q   <= cell_index_i;
            scr_q   <= 1'b0;
            rd_ok_q <= 1'b0;
            state_q <= ST_CALC;
          end
        end

        ST_CALC: begin
          if (act_q == ACT_READ) begin
            // An index past the screen reads as zero without a memory access.
            rd_ok_q <= in_range_w;
            state_q <= in_range_w ? ST_RD : ST_DONE;
          end else if (code_q == NEWLINE_CODE) begin
            col_q <= '0;
            if (row_q == LAST_ROW) begin
              lin_q   <= LAST_ROW_START;
              scr_q   <= 1'b1;
              state_q <= ST_SCRL;
            end else begin
              row_q   <= row_q + RW'(1);
              lin_q   <= lin_nl_w;
              state_q <= ST_DONE;
            end
          end else begin
            state_q <= ST_WR;
          end
        end

        ST_WR: begin
          if (col_q == LAST_COL) begin
            col_q <= '0;
            if (row_q == LAST_ROW) begin
              lin_q   <= LAST_ROW_START;
              scr_q   <= 1'b1;
              state_q <= ST_SCRL;
            end else begin
              row_q   <= row_q + RW'(1);
              lin_q   <= lin_q + AW'(1);
              state_q <= ST_DONE;
            end
          end else begin
            col_q   <= col_q + CW'(1);
            lin_q   <= lin_q + AW'(1);
            state_q <= ST_DONE;
          end
        end

        ST_RD: begin
          state_q <= ST_DONE;
        end

        ST_SCRL: begin
          // The old top row becomes the new bottom row of the ring.
          base_q     <= sum_w;
          blk_base_q <= base_q;
          blk_cnt_q  <= '0;
          state_q    <= ST_BLANK;
        end

        ST_BLANK: begin
          if (blk_cnt_q == LAST_COL) begin
            state_q <= ST_BLANK_END;
          end else begin
            blk_cnt_q <= blk_cnt_q + CW'(1);
          end
        end

        ST_BLANK_END: begin
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          if (load_out_w) begin
            out_valid_q <= 1'b1;
            cur_out_q   <= lin_ext_w[10:0];
            data_out_q  <= rd_ok_q ? ram_rdata_w : 16'd0;
            scr_out_q   <= scr_q;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = cur_out_q;
  assign cell_data_o       = data_out_q;
  assign scrolled_o        = scr_out_q;

  `TCCS_ASSERT_IMP(a_cursor_range, 1'b1, (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
  `TCCS_ASSERT_IMP(a_cursor_linear, 1'b1, 32'(lin_q) == 32'(row_q) * COLUMNS + 32'(col_q))
  `TCCS_ASSERT_IMP(a_base_range, 1'b1, (32'(base_q) < CELLS) && (32'(blk_base_q) < CELLS))
  `TCCS_ASSERT_NEXT(a_result_posted, load_out_w, out_valid_q && (state_q == ST_IDLE))

endmodule
